@@ src/mrsa_pkg.sv @@
// Shared types and constants of the multi-resource server allocator.
// Depends on nothing; imported by the allocator top level.
`default_nettype none

package mrsa_pkg;

  localparam int unsigned NUM_RES   = 4;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned NOW_W     = 47;
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned NEXT_ID_W = 17;
  localparam int unsigned COST_W    = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned RETIRED_W = 7;
  localparam int unsigned CLOSED_W  = 5;

  localparam logic [RES_W-1:0] CAP_RESET = 16'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAP0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP3 = 8'd3;

  // One server slot record
  typedef struct packed {
    logic [ID_W-1:0]                  id;
    logic [TIME_W-1:0]                start;
    logic [TIME_W-1:0]                fin;
    logic [NUM_RES-1:0][RES_W-1:0]    free;
  } srv_rec_t;

  // One active job record (owning slot index is kept beside it)
  typedef struct packed {
    logic [TIME_W-1:0]                fin;
    logic [ID_W-1:0]                  owner;
    logic [NUM_RES-1:0][RES_W-1:0]    demand;
  } job_rec_t;

endpackage

`default_nettype wire

@@ src/mrsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module mrsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/multi_resource_server_allocator.sv @@
// Allocator top level; depends on mrsa_pkg and mrsa_ram. Job walk: a read per empty slot,
// read and check per live one, plus a server update and maybe a close per retiring one;
// server walk: read and check per slot; then pick, read, write, done; done_o the cycle after.
// A full job table skips the server walk. busy_o is high until done_o, one beat at a time;
// the next beat can be taken at the edge that ends done_o. The receiver cannot stall.
// Reset clears valid bits, counters and cost and loads capacities of 1000; no clearing pass.
`default_nettype none

module multi_resource_server_allocator
  import mrsa_pkg::*;
#(
  parameter int unsigned MAX_SERVERS     = 16,
  parameter int unsigned MAX_ACTIVE_JOBS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [RES_W-1:0]     cfg_data_i,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [NOW_W-1:0]     now_i,
  input  wire logic [DUR_W-1:0]     duration_i,
  input  wire logic [RES_W-1:0]     demand_0_i,
  input  wire logic [RES_W-1:0]     demand_1_i,
  input  wire logic [RES_W-1:0]     demand_2_i,
  input  wire logic [RES_W-1:0]     demand_3_i,
  output logic                      done_o,
  output logic [ID_W-1:0]           server_number_o,
  output logic                      opened_new_o,
  output logic                      rejected_o,
  output logic [TIME_W-1:0]         job_end_o,
  output logic [RETIRED_W-1:0]      jobs_retired_o,
  output logic [CLOSED_W-1:0]       servers_closed_o,
  output logic [COST_W-1:0]         total_cost_o,
  output logic [ID_W-1:0]           servers_opened_o
);

  localparam int unsigned SW     = $clog2(MAX_SERVERS);
  localparam int unsigned JW     = $clog2(MAX_ACTIVE_JOBS);
  localparam int unsigned JREC_W = $bits(job_rec_t);
  localparam int unsigned SREC_W = $bits(srv_rec_t);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RJ_RD, ST_RJ_CHK, ST_RS_UPD, ST_RS_CLOSE,
    ST_FIT_RD, ST_FIT_CHK, ST_PICK, ST_AS_RD, ST_AS_WR, ST_DONE
  } state_e;

  state_e state_q;

  logic [NUM_RES-1:0][RES_W-1:0] cap_q;
  logic [NUM_RES-1:0][RES_W-1:0] dem_q;
  logic [NOW_W-1:0]              now_q;
  logic [TIME_W-1:0]             end_q;
  logic [MAX_SERVERS-1:0]        slot_valid_q;
  logic [MAX_ACTIVE_JOBS-1:0]    job_valid_q;
  logic [JW-1:0]                 j_q;
  logic [JW-1:0]                 jslot_q;
  logic                          jfound_q;
  logic [SW-1:0]                 srv_idx_q;
  logic [SW-1:0]                 best_q;
  logic                          best_found_q;
  logic [TIME_W-1:0]             best_end_q;
  logic [ID_W-1:0]               best_id_q;
  logic [SW-1:0]                 free_s_q;
  logic                          free_found_q;
  logic                          opened_q;
  logic                          rej_q;
  logic [ID_W-1:0]               sid_q;
  logic [TIME_W-1:0]             span_q;
  logic [RETIRED_W-1:0]          retired_q;
  logic [CLOSED_W-1:0]           closed_q;
  logic [NEXT_ID_W-1:0]          next_id_q;
  logic [COST_W-1:0]             cost_q;
  logic [ID_W-1:0]               opened_cnt_q;

  // RAM ports
  logic                 srv_we;
  logic [SW-1:0]        srv_raddr;
  logic [SREC_W-1:0]    srv_wdata;
  logic [SREC_W-1:0]    srv_rdata;
  logic                 job_we;
  logic [JREC_W+SW-1:0] job_wdata;
  logic [JREC_W+SW-1:0] job_rdata;

  srv_rec_t srv_rd;
  job_rec_t jrec;
  logic [SW-1:0] jrec_slot;

  logic                   job_old;
  logic                   hit;
  logic                   idle_all;
  logic                   close_ok;
  logic                   fits;
  logic                   better;
  logic                   j_last;
  logic                   s_last;
  logic [RES_W:0]         ret_sum;
  srv_rec_t               upd_rec;
  srv_rec_t               base_rec;
  srv_rec_t               as_rec;
  logic [TIME_W-1:0]      now_ext;
  logic [COST_W:0]        cost_sum;

  mrsa_ram #(.WIDTH(SREC_W), .DEPTH(MAX_SERVERS)) u_srv_ram (
    .clk_i   (clk_i),
    .we_i    (srv_we),
    .waddr_i (srv_idx_q),
    .wdata_i (srv_wdata),
    .raddr_i (srv_raddr),
    .rdata_o (srv_rdata)
  );

  mrsa_ram #(.WIDTH(JREC_W + SW), .DEPTH(MAX_ACTIVE_JOBS)) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (job_we),
    .waddr_i (jslot_q),
    .wdata_i (job_wdata),
    .raddr_i (j_q),
    .rdata_o (job_rdata)
  );

  // record decode and per-slot arithmetic
  always_comb begin
    srv_rd    = srv_rec_t'(srv_rdata);
    jrec      = job_rec_t'(job_rdata[JREC_W-1:0]);
    jrec_slot = job_rdata[JREC_W+SW-1:JREC_W];
    now_ext   = {1'b0, now_q};
    job_old   = jrec.fin < now_ext;
    hit       = slot_valid_q[srv_idx_q] && (srv_rd.id == jrec.owner);
    j_last    = (j_q == JW'(MAX_ACTIVE_JOBS - 1));
    s_last    = (srv_idx_q == SW'(MAX_SERVERS - 1));

    // return demands, saturating at current capacity
    upd_rec  = srv_rd;
    idle_all = 1'b1;
    ret_sum  = '0;
    for (int r = 0; r < NUM_RES; r++) begin
      ret_sum = {1'b0, srv_rd.free[r]} + {1'b0, jrec.demand[r]};
      upd_rec.free[r] = (ret_sum > {1'b0, cap_q[r]}) ? cap_q[r] : ret_sum[RES_W-1:0];
      if (upd_rec.free[r] != cap_q[r]) begin
        idle_all = 1'b0;
      end
    end
    close_ok = (srv_rd.fin <= now_ext) && idle_all;

    // fit test and best choice
    fits = slot_valid_q[srv_idx_q];
    for (int r = 0; r < NUM_RES; r++) begin
      if (srv_rd.free[r] < dem_q[r]) begin
        fits = 1'b0;
      end
    end
    better = !best_found_q || (srv_rd.fin > best_end_q) ||
             ((srv_rd.fin == best_end_q) && (srv_rd.id < best_id_q));

    // assignment record: fresh server or the chosen one
    if (opened_q) begin
      base_rec.id    = next_id_q[ID_W-1:0];
      base_rec.start = now_ext;
      base_rec.fin   = '0;
      base_rec.free  = cap_q;
    end else begin
      base_rec = srv_rd;
    end
    as_rec       = base_rec;
    as_rec.start = (now_ext < base_rec.start) ? now_ext : base_rec.start;
    as_rec.fin   = (end_q > base_rec.fin) ? end_q : base_rec.fin;
    for (int r = 0; r < NUM_RES; r++) begin
      as_rec.free[r] = (base_rec.free[r] > dem_q[r]) ? (base_rec.free[r] - dem_q[r]) : '0;
    end

    cost_sum = {1'b0, cost_q} + {{(COST_W - TIME_W + 1){1'b0}}, span_q};

    srv_we    = ((state_q == ST_RS_UPD) && hit) || (state_q == ST_AS_WR);
    srv_wdata = (state_q == ST_AS_WR) ? as_rec : upd_rec;
    srv_raddr = (state_q == ST_RJ_CHK) ? jrec_slot : srv_idx_q;
    job_we    = (state_q == ST_AS_WR);
    job_wdata = {srv_idx_q, job_rec_t'{fin: end_q, owner: base_rec.id, demand: dem_q}};
  end

  assign busy_o = (state_q != ST_IDLE);

  // sequencer, tables' valid bits and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      cap_q            <= {NUM_RES{CAP_RESET}};
      slot_valid_q     <= '0;
      job_valid_q      <= '0;
      next_id_q        <= '0;
      cost_q           <= '0;
      opened_cnt_q     <= '0;
      done_o           <= 1'b0;
      j_q              <= '0;
      srv_idx_q        <= '0;
      jfound_q         <= 1'b0;
      best_found_q     <= 1'b0;
      free_found_q     <= 1'b0;
      opened_q         <= 1'b0;
      rej_q            <= 1'b0;
      retired_q        <= '0;
      closed_q         <= '0;
      server_number_o  <= '0;
      opened_new_o     <= 1'b0;
      rejected_o       <= 1'b0;
      job_end_o        <= '0;
      jobs_retired_o   <= '0;
      servers_closed_o <= '0;
      total_cost_o     <= '0;
      servers_opened_o <= '0;
    end else begin
      done_o <= 1'b0;

      // capacity registers
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAP0: cap_q[0] <= cfg_data_i;
          CFG_CAP1: cap_q[1] <= cfg_data_i;
          CFG_CAP2: cap_q[2] <= cfg_data_i;
          CFG_CAP3: cap_q[3] <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            now_q        <= now_i;
            end_q        <= {1'b0, now_i} + {{(TIME_W - DUR_W){1'b0}}, duration_i};
            dem_q        <= {demand_3_i, demand_2_i, demand_1_i, demand_0_i};
            j_q          <= '0;
            jfound_q     <= 1'b0;
            best_found_q <= 1'b0;
            free_found_q <= 1'b0;
            opened_q     <= 1'b0;
            rej_q        <= 1'b0;
            retired_q    <= '0;
            closed_q     <= '0;
            state_q      <= ST_RJ_RD;
          end
        end

        // retirement walk over job slots
        ST_RJ_RD: begin
          if (job_valid_q[j_q]) begin
            state_q <= ST_RJ_CHK;
          end else begin
            if (!jfound_q) begin
              jslot_q  <= j_q;
              jfound_q <= 1'b1;
            end
            if (j_last) begin
              srv_idx_q <= '0;
              state_q   <= ST_FIT_RD;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end

        ST_RJ_CHK: begin
          if (job_old) begin
            job_valid_q[j_q] <= 1'b0;
            retired_q        <= retired_q + 1'b1;
            srv_idx_q        <= jrec_slot;
            if (!jfound_q) begin
              jslot_q  <= j_q;
              jfound_q <= 1'b1;
            end
            state_q <= ST_RS_UPD;
          end else if (j_last) begin
            srv_idx_q <= '0;
            state_q   <= ST_FIT_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_RJ_RD;
          end
        end

        ST_RS_UPD: begin
          if (hit && close_ok) begin
            slot_valid_q[srv_idx_q] <= 1'b0;
            closed_q <= closed_q + 1'b1;
            span_q   <= (srv_rd.fin >= srv_rd.start) ? (srv_rd.fin - srv_rd.start) : '0;
            state_q  <= ST_RS_CLOSE;
          end else if (j_last) begin
            srv_idx_q <= '0;
            state_q   <= ST_FIT_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_RJ_RD;
          end
        end

        ST_RS_CLOSE: begin
          cost_q <= cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
          if (j_last) begin
            srv_idx_q <= '0;
            state_q   <= ST_FIT_RD;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= ST_RJ_RD;
          end
        end

        // best-fit walk over server slots
        ST_FIT_RD: begin
          if (!jfound_q) begin
            rej_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_FIT_CHK;
          end
        end

        ST_FIT_CHK: begin
          if (fits && better) begin
            best_q       <= srv_idx_q;
            best_found_q <= 1'b1;
            best_end_q   <= srv_rd.fin;
            best_id_q    <= srv_rd.id;
          end
          if (!slot_valid_q[srv_idx_q] && !free_found_q) begin
            free_s_q     <= srv_idx_q;
            free_found_q <= 1'b1;
          end
          if (s_last) begin
            state_q <= ST_PICK;
          end else begin
            srv_idx_q <= srv_idx_q + 1'b1;
            state_q   <= ST_FIT_RD;
          end
        end

        ST_PICK: begin
          if (best_found_q) begin
            srv_idx_q <= best_q;
            state_q   <= ST_AS_RD;
          end else if (!free_found_q || next_id_q[NEXT_ID_W-1]) begin
            rej_q   <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            srv_idx_q <= free_s_q;
            opened_q  <= 1'b1;
            state_q   <= ST_AS_RD;
          end
        end

        ST_AS_RD: begin
          state_q <= ST_AS_WR;
        end

        ST_AS_WR: begin
          slot_valid_q[srv_idx_q] <= 1'b1;
          job_valid_q[jslot_q]    <= 1'b1;
          sid_q                   <= base_rec.id;
          if (opened_q) begin
            next_id_q <= next_id_q + 1'b1;
            if (opened_cnt_q != '1) begin
              opened_cnt_q <= opened_cnt_q + 1'b1;
            end
          end
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          done_o           <= 1'b1;
          server_number_o  <= rej_q ? '0 : sid_q;
          opened_new_o     <= opened_q;
          rejected_o       <= rej_q;
          job_end_o        <= rej_q ? '0 : end_q;
          jobs_retired_o   <= retired_q;
          servers_closed_o <= closed_q;
          total_cost_o     <= cost_q;
          servers_opened_o <= opened_cnt_q;
          state_q          <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result beat is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  // a rejected job names no server and opens none
  a_rej_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rejected_o) |-> (server_number_o == '0 && !opened_new_o && job_end_o == '0))
    else $error("rejected result carries assignment data");

  // an accepted job makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted job did not start the sequencer");

  // a new server implies the open counter moved or was saturated
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AS_WR && opened_q) |=> (opened_cnt_q != '0))
    else $error("opened server not counted");
`endif

endmodule

`default_nettype wire
